FILE: src/tfc_pkg.sv
// ----------------------------------------------------------------------------
// Time/frame converter package
// Field widths, timing constants and the side record that rides along the
// divider cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tfc_pkg;

    localparam int unsigned SEC_W   = 32;
    localparam int unsigned NSEC_W  = 31;
    localparam int unsigned FRAME_W = 52;
    localparam int unsigned RATE_W  = 20;
    // bits needed for one second counted in nanoseconds
    localparam int unsigned NS_W    = 30;

    // first divider row: frame magnitude or scaled nanoseconds over rate or 1e9
    localparam int unsigned DIV1_W  = FRAME_W;
    localparam int unsigned REM1_W  = NS_W;
    // second divider row: remainder * 1e9 over rate, quotient below 1e9
    localparam int unsigned DIV2_W  = NS_W;
    localparam int unsigned REM2_W  = RATE_W;

    localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

    localparam logic signed [NSEC_W-1:0] NSEC_POS     = 31'sd1000000000;
    localparam logic signed [NSEC_W-1:0] NSEC_NEG     = -31'sd1000000000;
    localparam logic signed [NSEC_W-1:0] NSEC_SAT_POS = 31'sd999999999;
    localparam logic signed [NSEC_W-1:0] NSEC_SAT_NEG = -31'sd999999999;

    localparam logic signed [SEC_W-1:0] SEC_MAX = 32'sh7FFFFFFF;
    localparam logic signed [SEC_W-1:0] SEC_MIN = 32'sh80000000;

    localparam logic [RATE_W-1:0] RATE_RESET = 20'd44100;

    localparam logic KIND_TIME  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // request record carried beside the divider data
    typedef struct packed {
        logic               kind;
        logic               neg;
        logic [FRAME_W-1:0] val;
    } side_t;

endpackage

`default_nettype wire

FILE: src/tfc_in_if.sv
// ----------------------------------------------------------------------------
// Conversion request channel
// Valid/ready channel carrying one timestamp or frame count request.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic signed [tfc_pkg::SEC_W-1:0]     seconds;
    logic signed [tfc_pkg::NSEC_W-1:0]    nanoseconds;
    logic signed [tfc_pkg::FRAME_W-1:0]   frame;

    modport source (output valid, kind, seconds, nanoseconds, frame, input ready);
    modport sink   (input valid, kind, seconds, nanoseconds, frame, output ready);
endinterface

`default_nettype wire

FILE: src/tfc_out_if.sv
// ----------------------------------------------------------------------------
// Conversion result channel
// Valid/ready channel carrying one frame count or timestamp result.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tfc_pkg::FRAME_W-1:0]   frame_out;
    logic signed [tfc_pkg::SEC_W-1:0]     seconds_out;
    logic signed [tfc_pkg::NSEC_W-1:0]    nanoseconds_out;
    logic                                 overflow;

    modport source (output valid, frame_out, seconds_out, nanoseconds_out, overflow,
                    input ready);
    modport sink   (input valid, frame_out, seconds_out, nanoseconds_out, overflow,
                    output ready);
endinterface

`default_nettype wire

FILE: src/tfc_cfg_if.sv
// ----------------------------------------------------------------------------
// Sample rate write channel
// Valid/ready channel carrying the sample rate register value.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tfc_pkg::RATE_W-1:0]      sample_rate;

    modport source (output valid, sample_rate, input ready);
    modport sink   (input valid, sample_rate, output ready);
endinterface

`default_nettype wire

FILE: src/tfc_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: shifts in the next dividend bit, subtracts the
// divisor when it fits and shifts the quotient bit into the low end.
// ----------------------------------------------------------------------------
`default_nettype none

module tfc_div_cell #(
    parameter int unsigned DW = tfc_pkg::REM1_W,
    parameter int unsigned NW = tfc_pkg::DIV1_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  logic [DW-1:0]         rem_in,
    input  logic [NW-1:0]         dq_in,
    input  tfc_pkg::side_t        side_in,
    input  logic [DW-1:0]         divisor,
    output logic                  valid_out,
    output logic [DW-1:0]         rem_out,
    output logic [NW-1:0]         dq_out,
    output tfc_pkg::side_t        side_out
);

    logic                 valid_reg;
    logic [DW-1:0]        rem_reg;
    logic [DW-1:0]        rem_next;
    logic [NW-1:0]        dq_reg;
    logic [NW-1:0]        dq_next;
    tfc_pkg::side_t       side_reg;
    logic [DW:0]          trial;
    logic [DW:0]          diff;
    logic                 take;

    always_comb
    begin
        trial    = {rem_in, dq_in[NW-1]};
        take     = (trial >= {1'b0, divisor});
        diff     = trial - {1'b0, divisor};
        rem_next = take ? diff[DW-1:0] : trial[DW-1:0];
        dq_next  = {dq_in[NW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            dq_reg   <= dq_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign dq_out    = dq_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

FILE: src/tfc_front.sv
// ----------------------------------------------------------------------------
// Converter front end
// Normalizes the timestamp, takes magnitudes and forms the products that
// feed the first divider row for time requests.
// ----------------------------------------------------------------------------
`default_nettype none

module tfc_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                valid_in,
    input  logic                                kind,
    input  logic signed [tfc_pkg::SEC_W-1:0]    seconds,
    input  logic signed [tfc_pkg::NSEC_W-1:0]   nanoseconds,
    input  logic signed [tfc_pkg::FRAME_W-1:0]  frame,
    input  logic [tfc_pkg::RATE_W-1:0]          rate,
    output logic                                valid_out,
    output logic [tfc_pkg::DIV1_W-1:0]          dq_out,
    output tfc_pkg::side_t                      side_out
);

    // stage A: whole seconds folded out of the nanoseconds
    logic                      a_valid_reg;
    logic                      a_kind_reg;
    logic [51:0]               a_frame_reg;
    logic signed [32:0]        a_s_reg;
    logic signed [32:0]        a_s_next;
    logic signed [30:0]        a_n_reg;
    logic signed [30:0]        a_n_next;
    logic signed [32:0]        s_ext;

    // stage B: common sign and magnitudes
    logic                      b_valid_reg;
    logic                      b_kind_reg;
    logic                      b_neg_reg;
    logic                      b_neg_next;
    logic [31:0]               b_ms_reg;
    logic [31:0]               b_ms_next;
    logic [29:0]               b_mn1_reg;
    logic [29:0]               b_mn1_next;
    logic [51:0]               b_fmag_reg;
    logic [51:0]               b_fmag_next;
    logic signed [32:0]        s2;
    logic signed [30:0]        n2;
    logic                      t_neg;
    logic [32:0]               s_neg;
    logic [30:0]               n_neg;
    logic [29:0]               mn;

    // stage M: products into the divider row
    logic                      m_valid_reg;
    logic [51:0]               m_dq_reg;
    logic [51:0]               m_dq_next;
    tfc_pkg::side_t            m_side_reg;
    tfc_pkg::side_t            m_side_next;
    logic [49:0]               prod_ns;
    logic [51:0]               prod_sec;

    always_comb
    begin
        s_ext = {seconds[31], seconds};
        if (nanoseconds >= tfc_pkg::NSEC_POS)
        begin
            a_s_next = s_ext + 33'sd1;
            a_n_next = nanoseconds - tfc_pkg::NSEC_POS;
        end
        else if (nanoseconds <= tfc_pkg::NSEC_NEG)
        begin
            a_s_next = s_ext - 33'sd1;
            a_n_next = nanoseconds + tfc_pkg::NSEC_POS;
        end
        else
        begin
            a_s_next = s_ext;
            a_n_next = nanoseconds;
        end
    end

    always_comb
    begin
        // move one second across when the parts disagree in sign
        if ((a_s_reg < 0) && (a_n_reg > 0))
        begin
            s2 = a_s_reg + 33'sd1;
            n2 = a_n_reg - tfc_pkg::NSEC_POS;
        end
        else if ((a_s_reg > 0) && (a_n_reg < 0))
        begin
            s2 = a_s_reg - 33'sd1;
            n2 = a_n_reg + tfc_pkg::NSEC_POS;
        end
        else
        begin
            s2 = a_s_reg;
            n2 = a_n_reg;
        end
        t_neg       = (s2 < 0) || ((s2 == 0) && (n2 < 0));
        s_neg       = ~s2 + 33'd1;
        n_neg       = ~n2 + 31'd1;
        b_ms_next   = t_neg ? s_neg[31:0] : s2[31:0];
        mn          = t_neg ? n_neg[29:0] : n2[29:0];
        b_mn1_next  = mn + 30'd1;
        b_fmag_next = a_frame_reg[51] ? (~a_frame_reg + 52'd1) : a_frame_reg;
        b_neg_next  = (a_kind_reg == tfc_pkg::KIND_FRAME) ? a_frame_reg[51] : t_neg;
    end

    always_comb
    begin
        prod_ns  = {20'd0, b_mn1_reg} * {30'd0, rate};
        prod_sec = {20'd0, b_ms_reg} * {32'd0, rate};
        m_side_next.kind = b_kind_reg;
        m_side_next.neg  = b_neg_reg;
        if (b_kind_reg == tfc_pkg::KIND_FRAME)
        begin
            m_dq_next       = b_fmag_reg;
            m_side_next.val = '0;
        end
        else
        begin
            m_dq_next       = {2'd0, prod_ns};
            m_side_next.val = prod_sec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= valid_in;
            b_valid_reg <= a_valid_reg;
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_kind_reg  <= kind;
            a_frame_reg <= frame;
            a_s_reg     <= a_s_next;
            a_n_reg     <= a_n_next;
            b_kind_reg  <= a_kind_reg;
            b_neg_reg   <= b_neg_next;
            b_ms_reg    <= b_ms_next;
            b_mn1_reg   <= b_mn1_next;
            b_fmag_reg  <= b_fmag_next;
            m_dq_reg    <= m_dq_next;
            m_side_reg  <= m_side_next;
        end
    end

    assign valid_out = m_valid_reg;
    assign dq_out    = m_dq_reg;
    assign side_out  = m_side_reg;

endmodule

`default_nettype wire

FILE: src/tfc_link.sv
// ----------------------------------------------------------------------------
// Divider row link
// Finishes the frame sum or keeps the whole seconds, and scales the
// remainder by 1e9 to feed the nanosecond divider row.
// ----------------------------------------------------------------------------
`default_nettype none

module tfc_link (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_in,
    input  logic [tfc_pkg::REM1_W-1:0]    rem_in,
    input  logic [tfc_pkg::DIV1_W-1:0]    dq_in,
    input  tfc_pkg::side_t                side_in,
    output logic                          valid_out,
    output logic [tfc_pkg::REM2_W-1:0]    rem_out,
    output logic [tfc_pkg::DIV2_W-1:0]    dq_out,
    output tfc_pkg::side_t                side_out
);

    logic                 valid_reg;
    logic [19:0]          rem_reg;
    logic [29:0]          dq_reg;
    tfc_pkg::side_t       side_reg;
    tfc_pkg::side_t       side_next;
    logic [49:0]          scaled;

    always_comb
    begin
        // remainder < rate, so the upper bits already form a valid partial remainder
        scaled         = {30'd0, rem_in[19:0]} * {20'd0, tfc_pkg::NS_PER_SEC};
        side_next.kind = side_in.kind;
        side_next.neg  = side_in.neg;
        if (side_in.kind == tfc_pkg::KIND_FRAME)
        begin
            side_next.val = dq_in;
        end
        else
        begin
            side_next.val = side_in.val + dq_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= scaled[49:30];
            dq_reg   <= scaled[29:0];
            side_reg <= side_next;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign dq_out    = dq_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

FILE: src/tfc_back.sv
// ----------------------------------------------------------------------------
// Converter back end
// Applies signs, saturates whole seconds and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tfc_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                valid_in,
    input  logic [tfc_pkg::DIV2_W-1:0]          quot,
    input  tfc_pkg::side_t                      side_in,
    input  logic                                rate_zero,
    output logic                                valid_out,
    output logic signed [tfc_pkg::FRAME_W-1:0]  frame_out,
    output logic signed [tfc_pkg::SEC_W-1:0]    seconds_out,
    output logic signed [tfc_pkg::NSEC_W-1:0]   nanoseconds_out,
    output logic                                overflow
);

    logic                 valid_reg;
    logic [51:0]          frame_reg;
    logic [51:0]          frame_next;
    logic [31:0]          sec_reg;
    logic [31:0]          sec_next;
    logic [30:0]          nsec_reg;
    logic [30:0]          nsec_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic [51:0]          q;
    logic [30:0]          ns_ext;
    logic                 sat_pos;
    logic                 sat_neg;

    always_comb
    begin
        q       = side_in.val;
        ns_ext  = {1'b0, quot};
        sat_pos = !side_in.neg && (q[51:31] != '0);
        sat_neg = side_in.neg && ((q[51:32] != '0) || (q[31] && (q[30:0] != '0)));

        frame_next = '0;
        sec_next   = '0;
        nsec_next  = '0;
        ovf_next   = 1'b0;
        if (side_in.kind == tfc_pkg::KIND_TIME)
        begin
            frame_next = side_in.neg ? (~q + 52'd1) : q;
        end
        else if (!rate_zero)
        begin
            if (sat_pos)
            begin
                sec_next  = tfc_pkg::SEC_MAX;
                nsec_next = tfc_pkg::NSEC_SAT_POS;
                ovf_next  = 1'b1;
            end
            else if (sat_neg)
            begin
                sec_next  = tfc_pkg::SEC_MIN;
                nsec_next = tfc_pkg::NSEC_SAT_NEG;
                ovf_next  = 1'b1;
            end
            else if (side_in.neg)
            begin
                sec_next  = ~q[31:0] + 32'd1;
                nsec_next = ~ns_ext + 31'd1;
            end
            else
            begin
                sec_next  = q[31:0];
                nsec_next = ns_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frame_reg <= frame_next;
            sec_reg   <= sec_next;
            nsec_reg  <= nsec_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign valid_out       = valid_reg;
    assign frame_out       = frame_reg;
    assign seconds_out     = sec_reg;
    assign nanoseconds_out = nsec_reg;
    assign overflow        = ovf_reg;

endmodule

`default_nettype wire

FILE: src/time_frame_converter_unit.sv
// ----------------------------------------------------------------------------
// Time/frame converter
// Converts seconds plus nanoseconds to a sample frame count and back at the
// programmed sample rate, through two rows of restoring divider cells.
// ----------------------------------------------------------------------------
//  channel | role   | handshake     | carries
//  cfg     | sink   | valid / ready | sample_rate (20 bits)
//  conv    | sink   | valid / ready | kind, seconds, nanoseconds, frame
//  res     | source | valid / ready | frame_out, seconds_out, nanoseconds_out,
//          |        |               | overflow
//
//  One request per cycle while no result is stalled; each passes the front
//  end, 52-cell quotient row, link, 30-cell nanosecond row and back end.
//  A result that is not taken holds the whole pipeline; conv.ready drops then.
//  Reset clears all valid bits and loads sample_rate with 44100.
//  cfg is always ready; write it only with no request in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module time_frame_converter_unit (
    input  logic        clk,
    input  logic        rst_n,
    tfc_cfg_if.sink     cfg,
    tfc_in_if.sink      conv,
    tfc_out_if.source   res
);

    localparam int unsigned D1 = tfc_pkg::DIV1_W;
    localparam int unsigned R1 = tfc_pkg::REM1_W;
    localparam int unsigned D2 = tfc_pkg::DIV2_W;
    localparam int unsigned R2 = tfc_pkg::REM2_W;

    logic [tfc_pkg::RATE_W-1:0]   rate_reg;
    logic [R1-1:0]                rate_ext;
    logic                         en;

    logic                         c1_valid [0:D1];
    logic [R1-1:0]                c1_rem   [0:D1];
    logic [D1-1:0]                c1_dq    [0:D1];
    tfc_pkg::side_t               c1_side  [0:D1];
    logic [R1-1:0]                c1_div   [0:D1-1];

    logic                         c2_valid [0:D2];
    logic [R2-1:0]                c2_rem   [0:D2];
    logic [D2-1:0]                c2_dq    [0:D2];
    tfc_pkg::side_t               c2_side  [0:D2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= tfc_pkg::RATE_RESET;
        end
        else if (cfg.valid)
        begin
            rate_reg <= cfg.sample_rate;
        end
    end

    assign cfg.ready = 1'b1;
    assign rate_ext  = {{(R1 - tfc_pkg::RATE_W){1'b0}}, rate_reg};

    // advance everything unless a finished result is stalled
    assign en        = !res.valid || res.ready;
    assign conv.ready = en;

    tfc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .valid_in    (conv.valid),
        .kind        (conv.kind),
        .seconds     (conv.seconds),
        .nanoseconds (conv.nanoseconds),
        .frame       (conv.frame),
        .rate        (rate_reg),
        .valid_out   (c1_valid[0]),
        .dq_out      (c1_dq[0]),
        .side_out    (c1_side[0])
    );

    assign c1_rem[0] = '0;

    genvar gi;
    for (gi = 0; gi < D1; gi++)
    begin : g_row1
        // time requests divide by one second in ns, frame requests by the rate
        assign c1_div[gi] = (c1_side[gi].kind == tfc_pkg::KIND_FRAME) ?
                            rate_ext : tfc_pkg::NS_PER_SEC;

        tfc_div_cell #(
            .DW (R1),
            .NW (D1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (c1_valid[gi]),
            .rem_in    (c1_rem[gi]),
            .dq_in     (c1_dq[gi]),
            .side_in   (c1_side[gi]),
            .divisor   (c1_div[gi]),
            .valid_out (c1_valid[gi+1]),
            .rem_out   (c1_rem[gi+1]),
            .dq_out    (c1_dq[gi+1]),
            .side_out  (c1_side[gi+1])
        );
    end

    tfc_link u_link (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (c1_valid[D1]),
        .rem_in    (c1_rem[D1]),
        .dq_in     (c1_dq[D1]),
        .side_in   (c1_side[D1]),
        .valid_out (c2_valid[0]),
        .rem_out   (c2_rem[0]),
        .dq_out    (c2_dq[0]),
        .side_out  (c2_side[0])
    );

    genvar gj;
    for (gj = 0; gj < D2; gj++)
    begin : g_row2
        tfc_div_cell #(
            .DW (R2),
            .NW (D2)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (c2_valid[gj]),
            .rem_in    (c2_rem[gj]),
            .dq_in     (c2_dq[gj]),
            .side_in   (c2_side[gj]),
            .divisor   (rate_reg),
            .valid_out (c2_valid[gj+1]),
            .rem_out   (c2_rem[gj+1]),
            .dq_out    (c2_dq[gj+1]),
            .side_out  (c2_side[gj+1])
        );
    end

    tfc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .valid_in        (c2_valid[D2]),
        .quot            (c2_dq[D2]),
        .side_in         (c2_side[D2]),
        .rate_zero       (rate_reg == '0),
        .valid_out       (res.valid),
        .frame_out       (res.frame_out),
        .seconds_out     (res.seconds_out),
        .nanoseconds_out (res.nanoseconds_out),
        .overflow        (res.overflow)
    );

endmodule

`default_nettype wire

FILE: src/tfc_checker.sv
// ----------------------------------------------------------------------------
// Time/frame converter checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tfc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                conv_ready,
    input  logic                                cfg_ready,
    input  logic                                res_valid,
    input  logic                                res_ready,
    input  logic signed [tfc_pkg::FRAME_W-1:0]  frame_out,
    input  logic signed [tfc_pkg::SEC_W-1:0]    seconds_out,
    input  logic signed [tfc_pkg::NSEC_W-1:0]   nanoseconds_out,
    input  logic                                overflow
);

    // a stalled result holds until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(frame_out) &&
        $stable(seconds_out) && $stable(nanoseconds_out) && $stable(overflow))
        else $error("result changed while stalled");

    // a stalled result freezes the pipeline, so no request may enter
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !conv_ready && cfg_ready)
        else $error("request accepted during result stall");

    a_ovf_limits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && overflow |->
        (seconds_out == tfc_pkg::SEC_MAX && nanoseconds_out == tfc_pkg::NSEC_SAT_POS) ||
        (seconds_out == tfc_pkg::SEC_MIN && nanoseconds_out == tfc_pkg::NSEC_SAT_NEG))
        else $error("overflow without saturated time");

    a_sign_agree: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !((seconds_out > 0) && (nanoseconds_out < 0)) &&
        !((seconds_out < 0) && (nanoseconds_out > 0)))
        else $error("seconds and nanoseconds differ in sign");

endmodule

bind time_frame_converter_unit tfc_checker u_tfc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .conv_ready      (conv.ready),
    .cfg_ready       (cfg.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .frame_out       (res.frame_out),
    .seconds_out     (res.seconds_out),
    .nanoseconds_out (res.nanoseconds_out),
    .overflow        (res.overflow)
);

`default_nettype wire
